>>> hdl/skt_pkg.sv
package skt_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned PayloadWidth = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND = 2'd2;
  localparam logic [1:0] OP_LIST = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic signed [KeyWidth-1:0] key;
    logic [PayloadWidth-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

>>> hdl/skt_mem.sv
module skt_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrWidth = 5
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  skt_pkg::entry_t      wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output skt_pkg::entry_t      rdata_o
);

  skt_pkg::entry_t mem_q [Depth];
  skt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/skt_cmp.sv
module skt_cmp (
  input  logic signed [skt_pkg::KeyWidth-1:0] entry_key_i,
  input  logic signed [skt_pkg::KeyWidth-1:0] probe_key_i,
  output skt_pkg::cmp_t                       res_o
);

  assign res_o.eq = (entry_key_i == probe_key_i);
  assign res_o.gt = (entry_key_i > probe_key_i);

endmodule

>>> hdl/sorted_key_table_top.sv
// Sorted key table: up to TABLE_DEPTH entries of signed key and payload, kept in ascending
// key order in a single-port-write, single-port-read memory, with one key comparator stepped
// over the entries by a sequencer. An operation is taken when start is high and busy is
// low. Insert walks down from the top entry, shifting larger entries up one place per cycle.
// Delete compacts the table in one pass. Find and list read one entry per cycle. An insert
// on a full table and a delete, find or list on an empty table answer in the next cycle. Each
// result word is shown for exactly one cycle with valid_o high and must be taken then; last_o
// marks the final word of an operation. After reset the table is empty and ready at once.
module sorted_key_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [1:0]                               opcode_i,
  input  logic signed [skt_pkg::KeyWidth-1:0]      account_key_i,
  input  logic [skt_pkg::PayloadWidth-1:0]         record_payload_i,
  output logic                                     valid_o,
  output logic [1:0]                               status_o,
  output logic signed [skt_pkg::KeyWidth-1:0]      entry_key_o,
  output logic [skt_pkg::PayloadWidth-1:0]         entry_payload_o,
  output logic                                     entry_present_o,
  output logic                                     last_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS = 3'd1;
  localparam logic [2:0] S_PUT = 3'd2;
  localparam logic [2:0] S_DEL = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]                          state_q, state_d;
  logic [1:0]                          op_q, op_d;
  logic signed [skt_pkg::KeyWidth-1:0] key_q, key_d;
  logic [skt_pkg::PayloadWidth-1:0]    pay_q, pay_d;
  logic [CW-1:0]                       cnt_q, cnt_d;
  logic [AW-1:0]                       idx_q, idx_d;
  logic [CW-1:0]                       wr_q, wr_d;
  skt_pkg::entry_t                     pend_q, pend_d;
  logic                                pend_v_q, pend_v_d;

  logic                                mem_we;
  logic [AW-1:0]                       mem_waddr;
  logic [AW-1:0]                       mem_raddr;
  skt_pkg::entry_t                     mem_wdata;
  skt_pkg::entry_t                     mem_rdata;
  skt_pkg::cmp_t                       cmp;
  skt_pkg::entry_t                     new_entry;
  logic                                last_idx;

  logic                                emit_v;
  logic [1:0]                          emit_st;
  skt_pkg::entry_t                     emit_ent;
  logic                                emit_pres;
  logic                                emit_last;

  logic                                valid_q;
  logic [1:0]                          status_q;
  skt_pkg::entry_t                     ent_q;
  logic                                present_q;
  logic                                last_q;

  skt_mem #(
    .Depth    (TABLE_DEPTH),
    .AddrWidth(AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  skt_cmp u_cmp (
    .entry_key_i(mem_rdata.key),
    .probe_key_i(key_q),
    .res_o      (cmp)
  );

  assign new_entry.key = key_q;
  assign new_entry.payload = pay_q;
  assign last_idx = (CW'(idx_q) == (cnt_q - CW'(1)));

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    key_d = key_q;
    pay_d = pay_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    wr_d = wr_q;
    pend_d = pend_q;
    pend_v_d = pend_v_q;
    mem_we = 1'b0;
    mem_waddr = AW'(CW'(idx_q) + CW'(1));
    mem_wdata = mem_rdata;
    mem_raddr = AW'(CW'(idx_q) + CW'(1));
    emit_v = 1'b0;
    emit_st = skt_pkg::ST_OK;
    emit_ent = '0;
    emit_pres = 1'b0;
    emit_last = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = (opcode_i == skt_pkg::OP_INSERT) ? AW'(cnt_q - CW'(1)) : '0;
        if (start) begin
          op_d = opcode_i;
          key_d = account_key_i;
          pay_d = record_payload_i;
          idx_d = '0;
          wr_d = '0;
          pend_v_d = 1'b0;
          unique case (opcode_i)
            skt_pkg::OP_INSERT: begin
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                emit_v = 1'b1;
                emit_st = skt_pkg::ST_FULL;
              end else if (cnt_q == '0) begin
                state_d = S_PUT;
              end else begin
                idx_d = AW'(cnt_q - CW'(1));
                state_d = S_INS;
              end
            end
            skt_pkg::OP_DELETE: begin
              if (cnt_q == '0) begin
                emit_v = 1'b1;
                emit_st = skt_pkg::ST_NONE;
              end else begin
                state_d = S_DEL;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                emit_v = 1'b1;
                emit_st = skt_pkg::ST_NONE;
              end else begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end
      S_INS: begin
        mem_raddr = AW'(idx_q - AW'(1));
        mem_we = 1'b1;
        if (cmp.gt) begin
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d = idx_q - AW'(1);
          end
        end else begin
          mem_wdata = new_entry;
          cnt_d = cnt_q + CW'(1);
          emit_v = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_waddr = '0;
        mem_wdata = new_entry;
        cnt_d = cnt_q + CW'(1);
        emit_v = 1'b1;
        state_d = S_IDLE;
      end
      S_DEL: begin
        mem_waddr = wr_q[AW-1:0];
        if (!cmp.eq) begin
          mem_we = 1'b1;
          wr_d = wr_q + CW'(1);
        end
        if (last_idx) begin
          cnt_d = wr_d;
          emit_v = 1'b1;
          emit_st = (wr_d != cnt_q) ? skt_pkg::ST_OK : skt_pkg::ST_NONE;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_SCAN: begin
        if ((op_q == skt_pkg::OP_LIST) || cmp.eq) begin
          if (pend_v_q) begin
            emit_v = 1'b1;
            emit_ent = pend_q;
            emit_pres = 1'b1;
            emit_last = 1'b0;
          end
          pend_d = mem_rdata;
          pend_v_d = 1'b1;
        end
        if (last_idx) begin
          state_d = S_FLUSH;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_FLUSH: begin
        emit_v = 1'b1;
        if (pend_v_q) begin
          emit_ent = pend_q;
          emit_pres = 1'b1;
        end else begin
          emit_st = skt_pkg::ST_NONE;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      pend_v_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pend_v_q <= pend_v_d;
      valid_q <= emit_v;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    key_q <= key_d;
    pay_q <= pay_d;
    idx_q <= idx_d;
    wr_q <= wr_d;
    pend_q <= pend_d;
    status_q <= emit_st;
    ent_q <= emit_ent;
    present_q <= emit_pres;
    last_q <= emit_last;
  end

  assign busy = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign status_o = status_q;
  assign entry_key_o = ent_q.key;
  assign entry_payload_o = ent_q.payload;
  assign entry_present_o = present_q;
  assign last_o = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_full_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == skt_pkg::OP_INSERT && cnt_q == CW'(TABLE_DEPTH))
    |=> (valid_o && status_o == skt_pkg::ST_FULL && last_o))
    else $error("full insert not answered");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> (state_q == S_IDLE))
    else $error("final word while sequencer busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (state_q != S_IDLE))
    else $error("non-final word with sequencer idle");

  a_bare_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !entry_present_o) |-> last_o)
    else $error("word without entry not final");

  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && entry_present_o) |-> (status_o == skt_pkg::ST_OK))
    else $error("entry word with bad status");

endmodule
